@@ hw/rtl/itaf_pkg.sv @@
`timescale 1ns / 1ps

package itaf_pkg;

    // ascii codes used by the formatter
    localparam logic [6:0] CH_SPACE = 7'h20;
    localparam logic [6:0] CH_PLUS  = 7'h2b;
    localparam logic [6:0] CH_MINUS = 7'h2d;
    localparam logic [6:0] CH_ZERO  = 7'h30;
    localparam logic [6:0] CH_LOW_A = 7'h61;

    // format flag bit positions
    localparam int FLG_ZERO   = 0;
    localparam int FLG_SIGNED = 1;
    localparam int FLG_PLUS   = 2;
    localparam int FLG_SPACE  = 3;
    localparam int FLG_LEFT   = 4;

    localparam logic [4:0] DEC_BASE = 5'd10;

    typedef enum logic [1:0] {
        RADIX_OCT = 2'd0,
        RADIX_DEC = 2'd1,
        RADIX_HEX = 2'd2
    } t_radix;

    // sequencer -> digit unit
    typedef struct packed {
        logic   load;
        logic   negate;
        logic   step;
        t_radix radix;
    } t_du_ctl;

    // digit unit -> sequencer
    typedef struct packed {
        logic busy;
        logic done;
        logic zero;
        logic msb;
    } t_du_sts;

    typedef enum logic [3:0] {
        PC_WAIT  = 4'd0,
        PC_PREP  = 4'd1,
        PC_DIV   = 4'd2,
        PC_LEN   = 4'd3,
        PC_LEAD  = 4'd4,
        PC_SIGN  = 4'd5,
        PC_ZPAD  = 4'd6,
        PC_DIGIT = 4'd7,
        PC_TRAIL = 4'd8
    } t_pc;

    typedef enum logic [2:0] {
        OP_WAIT = 3'd0,
        OP_PREP = 3'd1,
        OP_DIV  = 3'd2,
        OP_LEN  = 3'd3,
        OP_EMIT = 3'd4
    } t_op;

    typedef enum logic [2:0] {
        SRC_LEAD  = 3'd0,
        SRC_SIGN  = 3'd1,
        SRC_ZPAD  = 3'd2,
        SRC_DIGIT = 3'd3,
        SRC_TRAIL = 3'd4
    } t_src;

    typedef struct packed {
        t_op  op;
        t_src src;
        t_pc  next;
    } t_uword;

    // control store
    function automatic t_uword ucode(input t_pc pc);
        t_uword w;
        case (pc)
            PC_WAIT:  w = '{op: OP_WAIT, src: SRC_LEAD,  next: PC_PREP};
            PC_PREP:  w = '{op: OP_PREP, src: SRC_LEAD,  next: PC_DIV};
            PC_DIV:   w = '{op: OP_DIV,  src: SRC_LEAD,  next: PC_LEN};
            PC_LEN:   w = '{op: OP_LEN,  src: SRC_LEAD,  next: PC_LEAD};
            PC_LEAD:  w = '{op: OP_EMIT, src: SRC_LEAD,  next: PC_SIGN};
            PC_SIGN:  w = '{op: OP_EMIT, src: SRC_SIGN,  next: PC_ZPAD};
            PC_ZPAD:  w = '{op: OP_EMIT, src: SRC_ZPAD,  next: PC_DIGIT};
            PC_DIGIT: w = '{op: OP_EMIT, src: SRC_DIGIT, next: PC_TRAIL};
            PC_TRAIL: w = '{op: OP_EMIT, src: SRC_TRAIL, next: PC_WAIT};
            default:  w = '{op: OP_WAIT, src: SRC_LEAD,  next: PC_WAIT};
        endcase
        return w;
    endfunction

    function automatic logic [6:0] digit_char(input logic [3:0] d);
        logic [6:0] c;
        if (d < 4'd10) begin
            c = CH_ZERO + 7'(d);
        end else begin
            c = CH_LOW_A + 7'(d - 4'd10);
        end
        return c;
    endfunction

endpackage

@@ hw/rtl/itaf_digit_unit.sv @@
`timescale 1ns / 1ps

module itaf_digit_unit #(
    parameter int VALUE_BITS = 64
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  itaf_pkg::t_du_ctl       i_ctl,
    input  logic [VALUE_BITS-1:0]   i_value,
    output itaf_pkg::t_du_sts       o_sts,
    output logic [3:0]              o_digit
);
    import itaf_pkg::*;

    localparam int DIV_W  = ((VALUE_BITS + 7) / 8) * 8;
    localparam int CHUNKS = DIV_W / 8;
    localparam int CW     = (CHUNKS > 1) ? $clog2(CHUNKS) : 1;

    logic [DIV_W-1:0] r_val;
    logic [3:0]       r_rem;
    logic [3:0]       r_digit;
    logic [CW-1:0]    r_cnt;
    logic             r_busy;
    logic             r_done;
    logic [11:0]      chunk;

    // eight restoring steps of a divide by ten, msb first
    function automatic logic [11:0] div10_byte(input logic [3:0] rem, input logic [7:0] din);
        logic [4:0] acc;
        logic [3:0] r;
        logic [7:0] q;
        r = rem;
        q = '0;
        for (int i = 7; i >= 0; i--) begin
            acc = {r, din[i]};
            if (acc >= DEC_BASE) begin
                r    = 4'(acc - DEC_BASE);
                q[i] = 1'b1;
            end else begin
                r    = acc[3:0];
            end
        end
        return {r, q};
    endfunction

    assign chunk = div10_byte(r_rem, r_val[DIV_W-1 -: 8]);

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else if (i_ctl.load) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else if (r_busy) begin
            if (r_cnt == CW'(CHUNKS - 1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end else if (i_ctl.step) begin
            r_busy <= (i_ctl.radix == RADIX_DEC);
            r_done <= (i_ctl.radix != RADIX_DEC);
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_val <= DIV_W'(i_value);
        end else if (i_ctl.negate) begin
            r_val <= DIV_W'(VALUE_BITS'(~r_val[VALUE_BITS-1:0] + 1'b1));
        end else if (r_busy) begin
            r_val <= (r_val << 8) | DIV_W'(chunk[7:0]);
            r_rem <= chunk[11:8];
            r_cnt <= r_cnt + 1'b1;
            if (r_cnt == CW'(CHUNKS - 1)) begin
                r_digit <= chunk[11:8];
            end
        end else if (i_ctl.step) begin
            case (i_ctl.radix)
                RADIX_OCT: begin
                    r_val   <= r_val >> 3;
                    r_digit <= {1'b0, r_val[2:0]};
                end
                RADIX_DEC: begin
                    r_rem <= '0;
                    r_cnt <= '0;
                end
                default: begin
                    r_val   <= r_val >> 4;
                    r_digit <= r_val[3:0];
                end
            endcase
        end
    end

    assign o_sts.busy = r_busy;
    assign o_sts.done = r_done;
    assign o_sts.zero = (r_val == '0);
    assign o_sts.msb  = r_val[VALUE_BITS-1];
    assign o_digit    = r_digit;

endmodule

@@ hw/rtl/integer_to_ascii_formatter_core.sv @@
`timescale 1ns / 1ps

// channel   ports                                                   handshake
// --------  ------------------------------------------------------  -----------------------
// command   i_value, i_base_code, i_field_width, i_format_flags     taken when start & !busy
// result    o_out_char, o_last_char                                 one cycle, o_valid strobe
//
// an item runs the prep, divide and length steps, then the emit phases: an octal or hex digit
// is one shift, a decimal digit a divide by ten over the value a byte at a time, characters go
// out one per cycle within a phase, and leaving an emit phase is a step with no character
// one item at a time: busy stays high from acceptance until the last character is issued
// i_rst_n is synchronous; it returns the sequencer to its wait step with no strobe pending
// the receiver cannot stall, so every character is presented for exactly one cycle

module integer_to_ascii_formatter_core #(
    parameter int MAX_WIDTH  = 64,
    parameter int VALUE_BITS = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [63:0] i_value,
    input  logic [1:0]  i_base_code,
    input  logic [6:0]  i_field_width,
    input  logic [4:0]  i_format_flags,
    output logic        o_valid,
    output logic [6:0]  o_out_char,
    output logic        o_last_char
);
    import itaf_pkg::*;

    // worst case digit count is the octal one
    localparam int NDIG_MAX = (VALUE_BITS + 2) / 3;
    localparam int NDW      = $clog2(NDIG_MAX + 1);

    t_pc         r_pc, n_pc;
    t_radix      r_radix, n_radix;
    logic [6:0]  r_width, n_width;
    logic [4:0]  r_flags, n_flags;
    logic        r_has_sign, n_has_sign;
    logic [6:0]  r_sign_ch, n_sign_ch;
    logic [NDW-1:0] r_ndig, n_ndig;
    logic [6:0]  r_lead, n_lead;
    logic [6:0]  r_zpad, n_zpad;
    logic [6:0]  r_trail, n_trail;
    logic [6:0]  r_total, n_total;
    logic [6:0]  r_emit, n_emit;
    logic        r_valid, n_valid;
    logic [6:0]  r_out_char, n_out_char;
    logic        r_last_char, n_last_char;

    // digit stack: digits come out lsd first and leave msd first
    logic [3:0]  r_stack [NDIG_MAX];
    logic        push;
    logic        pop;

    t_uword      uw;
    t_du_ctl     du_ctl;
    t_du_sts     du_sts;
    logic [3:0]  du_digit;

    // length computation
    logic [6:0]  used;
    logic [6:0]  width_sat;
    logic [6:0]  pad;
    logic [6:0]  total_raw;

    // emit step
    logic        cnt_nz;
    logic [6:0]  emit_ch;
    logic        is_last;

    itaf_digit_unit #(
        .VALUE_BITS (VALUE_BITS)
    ) u_digit (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (du_ctl),
        .i_value (i_value[VALUE_BITS-1:0]),
        .o_sts   (du_sts),
        .o_digit (du_digit)
    );

    assign uw = ucode(r_pc);

    assign used      = 7'(r_ndig) + 7'(r_has_sign);
    assign width_sat = (r_width > 7'(MAX_WIDTH)) ? 7'(MAX_WIDTH) : r_width;
    assign pad       = (width_sat > used) ? (width_sat - used) : 7'd0;
    assign total_raw = used + pad;

    // current phase count and character
    always_comb begin
        case (uw.src)
            SRC_LEAD: begin
                cnt_nz  = (r_lead != '0);
                emit_ch = CH_SPACE;
            end
            SRC_SIGN: begin
                cnt_nz  = r_has_sign;
                emit_ch = r_sign_ch;
            end
            SRC_ZPAD: begin
                cnt_nz  = (r_zpad != '0);
                emit_ch = CH_ZERO;
            end
            SRC_DIGIT: begin
                cnt_nz  = (r_ndig != '0);
                emit_ch = digit_char(r_stack[0]);
            end
            default: begin
                cnt_nz  = (r_trail != '0);
                emit_ch = CH_SPACE;
            end
        endcase
    end

    assign is_last = ((r_emit + 7'd1) == r_total);

    // microcode sequencer: next step and datapath controls
    always_comb begin
        n_pc        = r_pc;
        n_radix     = r_radix;
        n_width     = r_width;
        n_flags     = r_flags;
        n_has_sign  = r_has_sign;
        n_sign_ch   = r_sign_ch;
        n_ndig      = r_ndig;
        n_lead      = r_lead;
        n_zpad      = r_zpad;
        n_trail     = r_trail;
        n_total     = r_total;
        n_emit      = r_emit;
        n_valid     = 1'b0;
        n_out_char  = r_out_char;
        n_last_char = r_last_char;
        push        = 1'b0;
        pop         = 1'b0;
        du_ctl        = '0;
        du_ctl.radix  = r_radix;

        case (uw.op)
            OP_WAIT: begin
                if (start) begin
                    n_pc       = uw.next;
                    n_width    = i_field_width;
                    n_flags    = i_format_flags;
                    n_has_sign = 1'b0;
                    n_ndig     = '0;
                    du_ctl.load = 1'b1;
                    case (i_base_code)
                        RADIX_OCT: n_radix = RADIX_OCT;
                        RADIX_DEC: n_radix = RADIX_DEC;
                        default:   n_radix = RADIX_HEX;
                    endcase
                end
            end
            OP_PREP: begin
                // sign decision; plus wins over space
                if (r_flags[FLG_SIGNED]) begin
                    if (du_sts.msb) begin
                        du_ctl.negate = 1'b1;
                        n_has_sign    = 1'b1;
                        n_sign_ch     = CH_MINUS;
                    end else if (r_flags[FLG_PLUS]) begin
                        n_has_sign = 1'b1;
                        n_sign_ch  = CH_PLUS;
                    end else if (r_flags[FLG_SPACE]) begin
                        n_has_sign = 1'b1;
                        n_sign_ch  = CH_SPACE;
                    end
                end
                n_pc = uw.next;
            end
            OP_DIV: begin
                // collect a finished digit and start the next one until quotient is zero
                if (du_sts.done) begin
                    push   = 1'b1;
                    n_ndig = r_ndig + 1'b1;
                end
                if (du_sts.done && du_sts.zero) begin
                    n_pc = uw.next;
                end else if (!du_sts.busy) begin
                    du_ctl.step = 1'b1;
                end
            end
            OP_LEN: begin
                // left justify wins over zero pad
                n_lead  = (!r_flags[FLG_ZERO] && !r_flags[FLG_LEFT]) ? pad : 7'd0;
                n_zpad  = (r_flags[FLG_ZERO] && !r_flags[FLG_LEFT]) ? pad : 7'd0;
                n_trail = r_flags[FLG_LEFT] ? pad : 7'd0;
                n_total = (total_raw > 7'(MAX_WIDTH)) ? 7'(MAX_WIDTH) : total_raw;
                n_emit  = '0;
                n_pc    = uw.next;
            end
            OP_EMIT: begin
                if (!cnt_nz) begin
                    n_pc = uw.next;
                end else begin
                    n_valid     = 1'b1;
                    n_out_char  = emit_ch;
                    n_last_char = is_last;
                    n_emit      = r_emit + 7'd1;
                    case (uw.src)
                        SRC_LEAD:  n_lead = r_lead - 7'd1;
                        SRC_SIGN:  n_has_sign = 1'b0;
                        SRC_ZPAD:  n_zpad = r_zpad - 7'd1;
                        SRC_DIGIT: begin
                            pop    = 1'b1;
                            n_ndig = r_ndig - 1'b1;
                        end
                        default:   n_trail = r_trail - 7'd1;
                    endcase
                    // output cut at the width limit ends the item early
                    if (is_last) begin
                        n_pc = PC_WAIT;
                    end
                end
            end
            default: begin
                n_pc = PC_WAIT;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc    <= PC_WAIT;
            r_valid <= 1'b0;
            r_ndig  <= '0;
            r_emit  <= '0;
        end else begin
            r_pc    <= n_pc;
            r_valid <= n_valid;
            r_ndig  <= n_ndig;
            r_emit  <= n_emit;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_radix     <= n_radix;
        r_width     <= n_width;
        r_flags     <= n_flags;
        r_has_sign  <= n_has_sign;
        r_sign_ch   <= n_sign_ch;
        r_lead      <= n_lead;
        r_zpad      <= n_zpad;
        r_trail     <= n_trail;
        r_total     <= n_total;
        r_out_char  <= n_out_char;
        r_last_char <= n_last_char;
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            for (int i = NDIG_MAX - 1; i > 0; i--) begin
                r_stack[i] <= r_stack[i-1];
            end
            r_stack[0] <= du_digit;
        end else if (pop) begin
            for (int i = 0; i < NDIG_MAX - 1; i++) begin
                r_stack[i] <= r_stack[i+1];
            end
        end
    end

    assign busy        = (r_pc != PC_WAIT);
    assign o_valid     = r_valid;
    assign o_out_char  = r_out_char;
    assign o_last_char = r_last_char;

`ifndef SYNTH
    // nothing follows the last character of an item in the next cycle
    a_last_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_last_char |=> !o_valid)
        else $error("character strobe right after last character");

    // an accepted item holds the block busy
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy)
        else $error("accepted item did not raise busy");

    // digit stack never overflows
    a_ndig_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ndig <= NDW'(NDIG_MAX))
        else $error("digit count beyond stack depth");

    // never more characters than the width limit
    a_emit_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_emit <= 7'(MAX_WIDTH))
        else $error("character count beyond width limit");
`endif

endmodule
